// ----- sv/lprd_pkg.sv -----
`default_nettype none
package lprd_pkg;

   // Every u32 field of the blob is this many bytes, least significant first.
   localparam int unsigned FIELD_BYTES = 4;
   localparam int unsigned FIELD_IDX_W = $clog2(FIELD_BYTES);
   localparam int unsigned FIELD_W     = 8 * FIELD_BYTES;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_MISSING_COUNT = 3'd1,
      ST_TRUNC_SIZE    = 3'd2,
      ST_TRUNC_PAYLOAD = 3'd3,
      ST_TRAILING      = 3'd4
   } status_type;

   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       blob_end;
   } item_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       element_first;
      logic       element_last;
      logic       blob_done;
      status_type status;
   } result_type;

endpackage
`default_nettype wire

// ----- sv/lprd_req_if.sv -----
`default_nettype none
interface lprd_req_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] data_byte;
   logic       blob_end;

   modport source (output valid, has_byte, data_byte, blob_end, input ready);
   modport sink   (input valid, has_byte, data_byte, blob_end, output ready);
endinterface
`default_nettype wire

// ----- sv/lprd_rsp_if.sv -----
`default_nettype none
interface lprd_rsp_if;
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic       element_first;
   logic       element_last;
   logic       blob_done;
   logic [2:0] status;

   modport source (output valid, payload_valid, payload_byte, element_first, element_last,
                   blob_done, status, input ready);
   modport sink   (input valid, payload_valid, payload_byte, element_first, element_last,
                   blob_done, status, output ready);
endinterface
`default_nettype wire

// ----- sv/lprd_core.sv -----
`default_nettype none
module lprd_core
   import lprd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire item_type   item,
   output result_type      result
);

   typedef enum logic [1:0] {
      PH_COUNT   = 2'd0,
      PH_SIZE    = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_DONE    = 2'd3
   } phase_type;

   localparam logic [FIELD_IDX_W-1:0] LAST_IDX = FIELD_IDX_W'(FIELD_BYTES - 1);

   phase_type              phase_ff, phase_in;
   logic [FIELD_IDX_W-1:0] idx_ff, idx_in;
   logic [FIELD_W-1:0]     field_ff, field_in;
   logic [FIELD_W-1:0]     elems_ff, elems_in;
   logic [FIELD_W-1:0]     left_ff, left_in;
   logic                   started_ff, started_in;
   status_type             err_ff, err_in;

   logic [FIELD_W-1:0]     field_full;
   logic [FIELD_W-1:0]     field_part;
   logic                   field_last;
   logic                   take;

   // The completed field is the bytes gathered so far with the top byte on top.
   assign field_full = {item.data_byte, field_ff[FIELD_W-9:0]};
   assign field_part = field_ff | (FIELD_W'(item.data_byte) << {idx_ff, 3'b000});
   assign field_last = (idx_ff == LAST_IDX);
   assign take       = item.has_byte && (err_ff == ST_OK);

   always_comb begin
      phase_in   = phase_ff;
      idx_in     = idx_ff;
      field_in   = field_ff;
      elems_in   = elems_ff;
      left_in    = left_ff;
      started_in = started_ff;
      err_in     = err_ff;
      result     = '0;

      if (take) begin
         case (phase_ff)
            PH_COUNT: begin
               if (field_last) begin
                  idx_in   = '0;
                  field_in = '0;
                  elems_in = field_full;
                  phase_in = (field_full == '0) ? PH_DONE : PH_SIZE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  field_in = field_part;
               end
            end
            PH_SIZE: begin
               if (field_last) begin
                  idx_in     = '0;
                  field_in   = '0;
                  left_in    = field_full;
                  elems_in   = elems_ff - 1'b1;
                  started_in = 1'b0;
                  if (field_full == '0) begin
                     result.element_first = 1'b1;
                     result.element_last  = 1'b1;
                     phase_in = (elems_ff == FIELD_W'(1)) ? PH_DONE : PH_SIZE;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  field_in = field_part;
               end
            end
            PH_PAYLOAD: begin
               result.payload_valid = 1'b1;
               result.payload_byte  = item.data_byte;
               result.element_first = !started_ff;
               started_in           = 1'b1;
               left_in              = left_ff - 1'b1;
               if (left_ff == FIELD_W'(1)) begin
                  result.element_last = 1'b1;
                  started_in          = 1'b0;
                  phase_in = (elems_ff == '0) ? PH_DONE : PH_SIZE;
               end
            end
            default: begin
               err_in = ST_TRAILING;
            end
         endcase
      end

      if (item.blob_end) begin
         result.blob_done = 1'b1;
         if (err_in != ST_OK) begin
            result.status = err_in;
         end else begin
            case (phase_in)
               PH_COUNT:   result.status = ST_MISSING_COUNT;
               PH_SIZE:    result.status = ST_TRUNC_SIZE;
               PH_PAYLOAD: result.status = ST_TRUNC_PAYLOAD;
               default:    result.status = ST_OK;
            endcase
         end
         phase_in   = PH_COUNT;
         idx_in     = '0;
         field_in   = '0;
         elems_in   = '0;
         left_in    = '0;
         started_in = 1'b0;
         err_in     = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_COUNT;
         idx_ff     <= '0;
         field_ff   <= '0;
         elems_ff   <= '0;
         left_ff    <= '0;
         started_ff <= 1'b0;
         err_ff     <= ST_OK;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         field_ff   <= field_in;
         elems_ff   <= elems_in;
         left_ff    <= left_in;
         started_ff <= started_in;
         err_ff     <= err_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/length_prefixed_record_deframer.sv -----
// Deframes a blob made of a 32-bit little-endian element count followed, for each
// element, by a 32-bit little-endian size and that many payload bytes. One word goes
// in per cycle while the sink keeps taking results, and exactly one word comes out
// for it, in order. Payload bytes come out with first/last marks, a zero-length
// element gives a word with both marks and no data, and the word for the blob's
// final input carries blob_done and a status (ok, missing count, truncated size,
// truncated payload, trailing bytes). Throughput is one word per cycle while the
// sink keeps taking results. The input register takes the word when it is accepted
// and the result register then takes its parsed result, from the single-pass parser
// update, when it is free or being emptied. The first error is held until the blob
// ends and later bytes give all-zero words.
`default_nettype none
module length_prefixed_record_deframer
   import lprd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   lprd_req_if.sink     req_chan,
   lprd_rsp_if.source   rsp_chan
);

   // Input register: holds one accepted word until the parser consumes it.
   logic       in_vld_ff, in_vld_in;
   item_type   in_ff;

   // Result register: holds one parsed word until the sink takes it.
   logic       out_vld_ff, out_vld_in;
   result_type out_ff;

   result_type step_result;
   logic       step_en;
   logic       req_take;

   // The parser advances whenever a word is waiting and the result register is
   // free or being emptied in this cycle, so both stages move together.
   assign step_en  = in_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || step_en;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_vld_in  = req_take || (in_vld_ff && !step_en);
   assign out_vld_in = step_en || (out_vld_ff && !rsp_chan.ready);

   lprd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      if (req_take) begin
         in_ff.has_byte  <= req_chan.has_byte;
         in_ff.data_byte <= req_chan.data_byte;
         in_ff.blob_end  <= req_chan.blob_end;
      end
      if (step_en) begin
         out_ff <= step_result;
      end
   end

   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.payload_valid = out_ff.payload_valid;
   assign rsp_chan.payload_byte  = out_ff.payload_byte;
   assign rsp_chan.element_first = out_ff.element_first;
   assign rsp_chan.element_last  = out_ff.element_last;
   assign rsp_chan.blob_done     = out_ff.blob_done;
   assign rsp_chan.status        = 3'(out_ff.status);

endmodule
`default_nettype wire

// ----- sv/lprd_checker.sv -----
`default_nettype none
module lprd_checker
   import lprd_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_payload_valid,
   input wire logic [7:0] rsp_payload_byte,
   input wire logic       rsp_element_first,
   input wire logic       rsp_element_last,
   input wire logic       rsp_blob_done,
   input wire logic [2:0] rsp_status
);

   // A status other than ok is only reported on the word that closes a blob.
   a_status_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_blob_done |-> rsp_status == 3'(ST_OK))
      else $error("status set on a word that does not end a blob");

   // Words without a payload byte carry a zero byte.
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |-> rsp_payload_byte == 8'd0)
      else $error("payload byte nonzero without payload_valid");

   // A last mark without data is only a zero-length element, which is also first.
   a_empty_element: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_element_last && !rsp_payload_valid |-> rsp_element_first)
      else $error("element_last without data and without element_first");

   // A stalled result word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_payload_byte) && $stable(rsp_blob_done))
      else $error("result word changed while stalled");

endmodule

bind length_prefixed_record_deframer lprd_checker u_lprd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_payload_valid (rsp_chan.payload_valid),
   .rsp_payload_byte  (rsp_chan.payload_byte),
   .rsp_element_first (rsp_chan.element_first),
   .rsp_element_last  (rsp_chan.element_last),
   .rsp_blob_done     (rsp_chan.blob_done),
   .rsp_status        (rsp_chan.status)
);
`default_nettype wire
